// ----- rtl/assert_macros.svh -----
// assertion macros for the triangle face normal unit
// no dependencies; the checks compile away when SYNTH is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TFN_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TFN_ASSERT_ALW(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`else
`define TFN_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define TFN_ASSERT_ALW(lbl, clk, rst, cond, msg)
`endif
`endif

// ----- rtl/tfn_pkg.sv -----
// shared constants of the triangle face normal unit
// no dependencies
`default_nettype none
package tfn_pkg;
  localparam int COORD_WIDTH_DEF      = 24;
  localparam int NORMAL_FRAC_BITS_DEF = 16;
  localparam int NUM_AXES             = 3;
  localparam int NUM_COORDS           = 9;
endpackage
`default_nettype wire

// ----- rtl/tfn_front.sv -----
// front pipeline: edges, cross product, squared components and squared length
// uses tfn_pkg
`default_nettype none
module tfn_front #(
  parameter int CW = tfn_pkg::COORD_WIDTH_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  input  wire  [tfn_pkg::NUM_COORDS-1:0][CW-1:0] in_data,
  output logic out_valid,
  input  wire  out_ready,
  output logic [tfn_pkg::NUM_AXES-1:0][2*(2*CW+1)-1:0] out_csq,
  output logic [2*(2*CW+1)+1:0] out_len2,
  output logic [tfn_pkg::NUM_AXES-1:0] out_neg,
  output logic out_deg
);
  localparam int EW  = CW + 1;
  localparam int PW  = 2 * EW;
  localparam int NMW = 2 * CW + 1;
  localparam int H   = (NMW + 1) / 2;
  localparam int HW  = NMW - H;
  localparam int SW  = 2 * NMW;
  localparam int LW  = SW + 2;

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  logic signed [EW-1:0] d [3];
  logic signed [EW-1:0] e [3];
  logic signed [PW-1:0] p [6];
  logic signed [PW-1:0] n_c [3];
  logic [NMW-1:0] mag [3];
  logic [2:0] neg3, neg4;
  logic [2*HW-1:0] hh [3];
  logic [HW+H-1:0] hl [3];
  logic [2*H-1:0]  ll [3];
  logic [SW-1:0] csq_c [3];
  logic [LW-1:0] len2_c;

  // ready chain, a stage loads when empty or when its successor moves
  assign r5 = !v5 || out_ready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  // stage 1: edge vectors
  always_ff @(posedge clk) begin
    if (r1) begin
      for (int i = 0; i < 3; i++) begin
        d[i] <= $signed({in_data[3+i][CW-1], in_data[3+i]})
              - $signed({in_data[i][CW-1], in_data[i]});
        e[i] <= $signed({in_data[6+i][CW-1], in_data[6+i]})
              - $signed({in_data[i][CW-1], in_data[i]});
      end
    end
  end

  // stage 2: edge products, p[0] to p[5]
  always_ff @(posedge clk) begin
    if (r2) begin
      p[0] <= PW'(d[1] * e[2]);
      p[1] <= PW'(d[2] * e[1]);
      p[2] <= PW'(d[2] * e[0]);
      p[3] <= PW'(d[0] * e[2]);
      p[4] <= PW'(d[0] * e[1]);
      p[5] <= PW'(d[1] * e[0]);
    end
  end

  // stage 3: cross product as magnitude and sign
  always_comb begin
    n_c[0] = p[0] - p[1];
    n_c[1] = p[2] - p[3];
    n_c[2] = p[4] - p[5];
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      for (int i = 0; i < 3; i++) begin
        neg3[i] <= n_c[i][PW-1];
        mag[i]  <= n_c[i][PW-1] ? NMW'(-n_c[i]) : NMW'(n_c[i]);
      end
    end
  end

  // stage 4: partial products of each square
  always_ff @(posedge clk) begin
    if (r4) begin
      neg4 <= neg3;
      for (int i = 0; i < 3; i++) begin
        hh[i] <= mag[i][NMW-1:H] * mag[i][NMW-1:H];
        hl[i] <= mag[i][NMW-1:H] * mag[i][H-1:0];
        ll[i] <= mag[i][H-1:0] * mag[i][H-1:0];
      end
    end
  end

  // stage 5: squares and squared length
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csq_c[i] = (SW'(hh[i]) << (2 * H)) + (SW'(hl[i]) << (H + 1)) + SW'(ll[i]);
    end
    len2_c = LW'(csq_c[0]) + LW'(csq_c[1]) + LW'(csq_c[2]);
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      for (int i = 0; i < 3; i++) out_csq[i] <= csq_c[i];
      out_len2 <= len2_c;
      out_neg  <= neg4;
      out_deg  <= (len2_c == '0);
    end
  end

  assign out_valid = v5;
endmodule
`default_nettype wire

// ----- rtl/tfn_cell.sv -----
// one quotient bit cell: trial step of q^2 * len2 <= c^2 * 2^2F for three axes
// uses tfn_pkg
`default_nettype none
module tfn_cell #(
  parameter int WW  = 137,
  parameter int LW  = 100,
  parameter int QW  = 17,
  parameter int BIT = 0
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_ready,
  input  wire  [LW-1:0] in_len2,
  input  wire  [tfn_pkg::NUM_AXES-1:0][WW-1:0] in_rem,
  input  wire  [tfn_pkg::NUM_AXES-1:0][WW-1:0] in_acc,
  input  wire  [tfn_pkg::NUM_AXES-1:0][QW-1:0] in_q,
  input  wire  [tfn_pkg::NUM_AXES-1:0] in_neg,
  input  wire  in_deg,
  output logic out_valid,
  input  wire  out_ready,
  output logic [LW-1:0] out_len2,
  output logic [tfn_pkg::NUM_AXES-1:0][WW-1:0] out_rem,
  output logic [tfn_pkg::NUM_AXES-1:0][WW-1:0] out_acc,
  output logic [tfn_pkg::NUM_AXES-1:0][QW-1:0] out_q,
  output logic [tfn_pkg::NUM_AXES-1:0] out_neg,
  output logic out_deg
);
  logic [WW-1:0] trial [3];
  logic [2:0] pass;
  logic [WW-1:0] len_w;

  assign in_ready = !out_valid || out_ready;
  assign len_w = WW'(in_len2);

  // trial term 2^(b+1) q len2 + 2^(2b) len2
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k] = (in_acc[k] << (BIT + 1)) + (len_w << (2 * BIT));
      pass[k]  = (in_rem[k] >= trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_len2 <= in_len2;
      out_neg  <= in_neg;
      out_deg  <= in_deg;
      for (int k = 0; k < 3; k++) begin
        out_rem[k] <= pass[k] ? in_rem[k] - trial[k] : in_rem[k];
        out_acc[k] <= pass[k] ? in_acc[k] + (len_w << BIT) : in_acc[k];
        out_q[k]   <= in_q[k] | (QW'(pass[k]) << BIT);
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/triangle_face_normal_unit.sv -----
// triangle face normal unit: five front stages, one cell per quotient bit, output register
// uses tfn_pkg, tfn_front, tfn_cell and assert_macros.svh
// throughput: one item per cycle while m_tready holds; a stage or cell hands on whenever its successor is ready
// reset: synchronous, clears all valid flags; payload registers are not reset
`default_nettype none
`include "assert_macros.svh"
module triangle_face_normal_unit #(
  parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  s_tvalid,
  output logic s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from lowest bit, zero pad
  input  wire  [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  wire  m_tready,
  // normal_x, normal_y, normal_z from lowest bit, zero pad
  output logic [((3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
  // degenerate
  output logic m_tuser
);
  localparam int CW  = COORD_WIDTH;
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int NMW = 2 * CW + 1;
  localparam int SW  = 2 * NMW;
  localparam int LW  = SW + 2;
  localparam int WW  = 2 * NMW + 2 * F + 5;
  localparam int QW  = F + 1;
  localparam int OW  = F + 2;
  localparam int NC  = F + 1;
  localparam int ODW = ((3*OW+7)/8)*8;

  logic f_valid, f_ready, f_deg;
  logic [2:0][SW-1:0] f_csq;
  logic [LW-1:0] f_len2;
  logic [2:0] f_neg;

  tfn_front #(.CW(CW)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_data(s_tdata[9*CW-1:0]),
    .out_valid(f_valid), .out_ready(f_ready),
    .out_csq(f_csq), .out_len2(f_len2), .out_neg(f_neg), .out_deg(f_deg)
  );

  // chain wiring, index 0 feeds the most significant bit cell
  logic [NC:0] c_valid, c_ready, c_deg;
  logic [LW-1:0] c_len2 [NC+1];
  logic [2:0][WW-1:0] c_rem [NC+1];
  logic [2:0][WW-1:0] c_acc [NC+1];
  logic [2:0][QW-1:0] c_q [NC+1];
  logic [2:0] c_neg [NC+1];

  // chain head: remainder starts at c^2 * 2^2F
  assign c_valid[0] = f_valid;
  assign c_len2[0]  = f_len2;
  assign c_neg[0]   = f_neg;
  assign c_deg[0]   = f_deg;
  for (genvar k = 0; k < 3; k++) begin : g_head
    assign c_rem[0][k] = WW'(f_csq[k]) << (2 * F);
    assign c_acc[0][k] = '0;
    assign c_q[0][k]   = '0;
  end
  assign f_ready = c_ready[0];

  for (genvar g = 0; g < NC; g++) begin : g_cell
    tfn_cell #(.WW(WW), .LW(LW), .QW(QW), .BIT(F - g)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(c_valid[g]), .in_ready(c_ready[g]),
      .in_len2(c_len2[g]), .in_rem(c_rem[g]), .in_acc(c_acc[g]),
      .in_q(c_q[g]), .in_neg(c_neg[g]), .in_deg(c_deg[g]),
      .out_valid(c_valid[g+1]), .out_ready(c_ready[g+1]),
      .out_len2(c_len2[g+1]), .out_rem(c_rem[g+1]), .out_acc(c_acc[g+1]),
      .out_q(c_q[g+1]), .out_neg(c_neg[g+1]), .out_deg(c_deg[g+1])
    );
  end

  // output register: sign, degenerate forcing
  logic o_valid, o_ready, o_deg;
  logic signed [OW-1:0] o_norm [3];

  assign o_ready = !o_valid || m_tready;
  assign c_ready[NC] = o_ready;

  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (o_ready) o_valid <= c_valid[NC];
  end

  always_ff @(posedge clk) begin
    if (o_ready) begin
      o_deg <= c_deg[NC];
      for (int k = 0; k < 3; k++) begin
        if (c_deg[NC]) o_norm[k] <= '0;
        else if (c_neg[NC][k]) o_norm[k] <= -$signed({1'b0, c_q[NC][k]});
        else o_norm[k] <= $signed({1'b0, c_q[NC][k]});
      end
    end
  end

  assign m_tvalid = o_valid;
  assign m_tuser  = o_deg;
  assign m_tdata  = ODW'({o_norm[2], o_norm[1], o_norm[0]});

  // checks
  `TFN_ASSERT_IMP(a_deg_zero, clk, rst, o_valid && o_deg,
    o_norm[0] == '0 && o_norm[1] == '0 && o_norm[2] == '0, "degenerate item not zero")
  `TFN_ASSERT_IMP(a_live_nonzero, clk, rst, o_valid && !o_deg,
    o_norm[0] != '0 || o_norm[1] != '0 || o_norm[2] != '0, "normal is zero vector")
  `TFN_ASSERT_ALW(a_unit_bound, clk, rst,
    !o_valid || (c_q[NC][0] <= (QW'(1) << F) || c_deg[NC] || !c_valid[NC]),
    "quotient above one")
endmodule
`default_nettype wire
